// ===== rtl/bmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared types and constants for the banked memory decoder.
// ----------------------------------------------------------------------------
package bmd_pkg;

    // Access modes carried in the input beat.
    typedef enum logic [2:0] {
        MODE_READ         = 3'd0,
        MODE_WRITE        = 3'd1,
        MODE_DIRECT_READ  = 3'd2,
        MODE_DIRECT_WRITE = 3'd3,
        MODE_LOAD_OS      = 3'd4,
        MODE_LOAD_CART    = 3'd5,
        MODE_RSVD6        = 3'd6,
        MODE_RSVD7        = 3'd7
    } mode_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_IO_CONNECTED = 1'b0,
        CFG_BANK_ADDR    = 1'b1
    } cfg_index_t;

    // Source of a read byte.
    typedef enum logic [1:0] {
        SRC_RAM  = 2'd0,
        SRC_OS   = 2'd1,
        SRC_CART = 2'd2,
        SRC_NONE = 2'd3
    } src_t;

    localparam logic [15:0] IO_BASE          = 16'hD000;
    localparam logic [15:0] IO_END           = 16'hD800;
    localparam logic [15:0] OS_BASE          = 16'hC000;
    localparam logic [15:0] CART_BASE        = 16'hA000;
    localparam logic [15:0] SELFTEST_BASE    = 16'h5000;
    localparam logic [15:0] SELFTEST_END     = 16'h5800;
    localparam logic [15:0] SELFTEST_OFFSET  = 16'h1000;
    localparam logic [15:0] BANK_ADDR_RESET  = 16'd54017;

    // Bank-control bit positions.
    localparam int BC_OS_BIT       = 0;
    localparam int BC_CART_BIT     = 1;
    localparam int BC_SELFTEST_BIT = 7;

endpackage

// ===== rtl/bmd_ram.sv =====
// ----------------------------------------------------------------------------
// bmd_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/banked_memory_decoder.sv =====
// ----------------------------------------------------------------------------
// banked_memory_decoder
// Address decoder for a 64K 8-bit machine map with RAM, OS ROM, cartridge
// ROM, an I/O window and bank switching through a shadowed control byte.
// ----------------------------------------------------------------------------
// After reset the block sweeps all three memories to zero, one entry per
// cycle; s_axis_tready stays low during the sweep while configuration
// writes are still taken. Each accepted beat is handled one byte at a time
// through single-port RAMs with registered read data: after the accept in
// the idle state, a byte read goes through an issue and a capture state,
// a byte write or ROM load through an issue state alone; reads and writes
// wait in the issue state until the output register is free. A write of
// the bank-control address register is taken in any state; outside the
// clear sweep, once the block is idle, it reloads the shadow byte from RAM
// through a read and a capture state before the next beat is taken. Result
// beats sit in a one-entry output register, so a new beat is taken while
// the last result waits downstream.
// ----------------------------------------------------------------------------
module banked_memory_decoder
    import bmd_pkg::*;
#(
    parameter int RAM_DEPTH      = 65536,
    parameter int OS_ROM_DEPTH   = 16384,
    parameter int CART_ROM_DEPTH = 8192
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,

    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address[15:0], write_data[31:16]
    input  logic [3:0]  s_axis_tuser,   // mode[2:0], word_access[3]

    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // byte_address[15:0], read_data[23:16],
                                        // io_data[31:24]
    output logic [2:0]  m_axis_tuser,   // io_read[0], io_write[1], write_dropped[2]
    output logic        m_axis_tlast
);

    localparam int RAM_AW  = $clog2(RAM_DEPTH);
    localparam int OS_AW   = $clog2(OS_ROM_DEPTH);
    localparam int CART_AW = $clog2(CART_ROM_DEPTH);

    typedef enum logic [5:0] {
        S_CLEAR      = 6'b000001,
        S_IDLE       = 6'b000010,
        S_ISSUE      = 6'b000100,
        S_CAP        = 6'b001000,
        S_RELOAD_RD  = 6'b010000,
        S_RELOAD_CAP = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [RAM_AW-1:0] clear_cnt_reg, clear_cnt_next;

    // configuration and bank shadow
    logic        io_conn_reg, io_conn_next;
    logic [15:0] bank_addr_reg, bank_addr_next;
    logic [7:0]  bank_reg, bank_next;
    logic        reload_reg, reload_next;     // shadow reload pending

    // current item
    mode_t       mode_reg, mode_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] data_reg, data_next;
    logic        word_reg, word_next;
    logic        second_reg, second_next;

    // read capture
    src_t        cap_src_reg, cap_src_next;
    logic [15:0] cap_addr_reg, cap_addr_next;
    logic        cap_io_reg, cap_io_next;
    logic        cap_last_reg, cap_last_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_addr_reg, out_addr_next;
    logic [7:0]  out_rdata_reg, out_rdata_next;
    logic        out_ior_reg, out_ior_next;
    logic        out_iow_reg, out_iow_next;
    logic [7:0]  out_iod_reg, out_iod_next;
    logic        out_drop_reg, out_drop_next;
    logic        out_last_reg, out_last_next;

    // memory ports
    logic                ram_we, os_we, cart_we;
    logic [RAM_AW-1:0]   ram_addr;
    logic [OS_AW-1:0]    os_addr;
    logic [CART_AW-1:0]  cart_addr;
    logic [7:0]          ram_wdata, os_wdata, cart_wdata;
    logic [7:0]          ram_rdata, os_rdata, cart_rdata;

    // decode of the byte in flight
    logic [15:0] cur_addr;
    logic [7:0]  cur_byte;
    logic        cur_last;
    logic        is_read, is_write, is_load, is_direct;
    logic        mapped;
    logic        in_io, in_os, in_cart, in_selftest;
    logic        os_on, cart_on, selftest_on;
    logic        keep;
    logic        out_free;
    logic [15:0] os_off, st_off, cart_off;
    logic [7:0]  cap_byte;
    src_t        rd_src;

    assign cur_addr = second_reg ? (addr_reg + 16'd1) : addr_reg;
    assign cur_byte = second_reg ? data_reg[15:8] : data_reg[7:0];
    assign cur_last = !word_reg || second_reg;

    assign is_read   = (mode_reg == MODE_READ) || (mode_reg == MODE_DIRECT_READ);
    assign is_write  = (mode_reg == MODE_WRITE) || (mode_reg == MODE_DIRECT_WRITE);
    assign is_load   = (mode_reg == MODE_LOAD_OS) || (mode_reg == MODE_LOAD_CART);
    assign is_direct = (mode_reg == MODE_DIRECT_READ) || (mode_reg == MODE_DIRECT_WRITE);
    assign mapped    = io_conn_reg && !is_direct;

    // region compares
    assign in_io       = (cur_addr >= IO_BASE) && (cur_addr < IO_END);
    assign in_os       = (cur_addr >= OS_BASE);
    assign in_cart     = (cur_addr >= CART_BASE) && (cur_addr < OS_BASE);
    assign in_selftest = (cur_addr >= SELFTEST_BASE) && (cur_addr < SELFTEST_END);

    assign os_on       = bank_reg[BC_OS_BIT];
    assign cart_on     = !bank_reg[BC_CART_BIT];
    assign selftest_on = os_on && !bank_reg[BC_SELFTEST_BIT];

    assign os_off   = cur_addr - OS_BASE;
    assign st_off   = cur_addr - SELFTEST_BASE + SELFTEST_OFFSET;
    assign cart_off = cur_addr - CART_BASE;

    // read source; I/O window wins, then OS, cartridge, self-test
    always_comb
    begin
        priority if (!mapped)
            rd_src = SRC_RAM;
        else if (in_io)
            rd_src = SRC_NONE;
        else if (in_os && os_on)
            rd_src = SRC_OS;
        else if (in_cart && cart_on)
            rd_src = SRC_CART;
        else if (in_selftest && selftest_on)
            rd_src = SRC_OS;
        else
            rd_src = SRC_RAM;
    end

    // write is stored unless its ROM is mapped over it
    always_comb
    begin
        priority if (!mapped)
            keep = 1'b1;
        else if (in_os)
            keep = !os_on;
        else if (cur_addr >= CART_BASE)
            keep = !cart_on;
        else if (in_selftest)
            keep = !selftest_on;
        else
            keep = 1'b1;
    end

    always_comb
    begin
        unique case (cap_src_reg)
            SRC_RAM:  cap_byte = ram_rdata;
            SRC_OS:   cap_byte = os_rdata;
            SRC_CART: cap_byte = cart_rdata;
            SRC_NONE: cap_byte = 8'd0;
            default:  cap_byte = 8'd0;
        endcase
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_write && !reload_reg;

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        io_conn_next   = io_conn_reg;
        bank_addr_next = bank_addr_reg;
        bank_next      = bank_reg;
        reload_next    = reload_reg;
        mode_next      = mode_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        word_next      = word_reg;
        second_next    = second_reg;
        cap_src_next   = cap_src_reg;
        cap_addr_next  = cap_addr_reg;
        cap_io_next    = cap_io_reg;
        cap_last_next  = cap_last_reg;

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_addr_next  = out_addr_reg;
        out_rdata_next = out_rdata_reg;
        out_ior_next   = out_ior_reg;
        out_iow_next   = out_iow_reg;
        out_iod_next   = out_iod_reg;
        out_drop_next  = out_drop_reg;
        out_last_next  = out_last_reg;

        ram_we     = 1'b0;
        os_we      = 1'b0;
        cart_we    = 1'b0;
        ram_addr   = cur_addr[RAM_AW-1:0];
        os_addr    = cur_addr[OS_AW-1:0];
        cart_addr  = cur_addr[CART_AW-1:0];
        ram_wdata  = cur_byte;
        os_wdata   = cur_byte;
        cart_wdata = cur_byte;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IO_CONNECTED: io_conn_next = cfg_data[0];
                CFG_BANK_ADDR:
                begin
                    // outside the clear sweep the shadow is reloaded from RAM once the block is idle
                    bank_addr_next = cfg_data;
                    reload_next    = 1'b1;
                end
                default:          io_conn_next = io_conn_reg;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // memories sweep to zero; RAM is all zero so the shadow is too
                ram_we         = 1'b1;
                os_we          = 1'b1;
                cart_we        = 1'b1;
                ram_addr       = clear_cnt_reg;
                os_addr        = clear_cnt_reg[OS_AW-1:0];
                cart_addr      = clear_cnt_reg[CART_AW-1:0];
                ram_wdata      = 8'd0;
                os_wdata       = 8'd0;
                cart_wdata     = 8'd0;
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (cfg_write && cfg_index == CFG_BANK_ADDR)
                begin
                    bank_next   = 8'd0;
                    reload_next = 1'b0;
                end
                if (&clear_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (reload_next)
                begin
                    reload_next = 1'b0;
                    state_next  = S_RELOAD_RD;
                end
                else if (s_axis_tvalid && s_axis_tready)
                begin
                    mode_next   = mode_t'(s_axis_tuser[2:0]);
                    word_next   = s_axis_tuser[3];
                    addr_next   = s_axis_tdata[15:0];
                    data_next   = s_axis_tdata[31:16];
                    second_next = 1'b0;
                    state_next  = S_ISSUE;
                end
            end

            S_ISSUE:
            begin
                if (is_read)
                begin
                    if (out_free)
                    begin
                        unique case (rd_src)
                            SRC_OS:
                                os_addr = (in_os ? os_off[OS_AW-1:0] : st_off[OS_AW-1:0]);
                            SRC_CART:
                                cart_addr = cart_off[CART_AW-1:0];
                            SRC_RAM, SRC_NONE:
                                ram_addr = cur_addr[RAM_AW-1:0];
                            default:
                                ram_addr = cur_addr[RAM_AW-1:0];
                        endcase
                        cap_src_next  = rd_src;
                        cap_addr_next = cur_addr;
                        cap_io_next   = (rd_src == SRC_NONE);
                        cap_last_next = cur_last;
                        state_next    = S_CAP;
                    end
                end
                else if (is_write)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_addr_next  = cur_addr;
                        out_rdata_next = 8'd0;
                        out_ior_next   = 1'b0;
                        out_last_next  = cur_last;
                        if (mapped && in_io)
                        begin
                            // forwarded to the I/O device, RAM untouched
                            out_iow_next  = 1'b1;
                            out_iod_next  = cur_byte;
                            out_drop_next = 1'b0;
                        end
                        else
                        begin
                            out_iow_next  = 1'b0;
                            out_iod_next  = 8'd0;
                            out_drop_next = !keep;
                            ram_we        = keep;
                            if (keep && cur_addr == bank_addr_reg)
                            begin
                                bank_next = cur_byte;
                            end
                        end
                        if (cur_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            second_next = 1'b1;
                        end
                    end
                end
                else if (is_load)
                begin
                    os_we   = (mode_reg == MODE_LOAD_OS);
                    cart_we = (mode_reg == MODE_LOAD_CART);
                    if (cur_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        second_next = 1'b1;
                    end
                end
                else
                begin
                    // reserved modes: no effect, no result
                    state_next = S_IDLE;
                end
            end

            S_CAP:
            begin
                // output register was free at issue and nothing else loads it
                out_valid_next = 1'b1;
                out_addr_next  = cap_addr_reg;
                out_rdata_next = cap_byte;
                out_ior_next   = cap_io_reg;
                out_iow_next   = 1'b0;
                out_iod_next   = 8'd0;
                out_drop_next  = 1'b0;
                out_last_next  = cap_last_reg;
                if (cap_last_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    second_next = 1'b1;
                    state_next  = S_ISSUE;
                end
            end

            S_RELOAD_RD:
            begin
                ram_addr   = bank_addr_reg[RAM_AW-1:0];
                state_next = S_RELOAD_CAP;
            end

            S_RELOAD_CAP:
            begin
                bank_next  = ram_rdata;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
            io_conn_reg   <= 1'b0;
            bank_addr_reg <= BANK_ADDR_RESET;
            bank_reg      <= 8'd0;
            reload_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            io_conn_reg   <= io_conn_next;
            bank_addr_reg <= bank_addr_next;
            bank_reg      <= bank_next;
            reload_reg    <= reload_next;
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        addr_reg      <= addr_next;
        data_reg      <= data_next;
        word_reg      <= word_next;
        cap_src_reg   <= cap_src_next;
        cap_addr_reg  <= cap_addr_next;
        cap_io_reg    <= cap_io_next;
        cap_last_reg  <= cap_last_next;
        out_addr_reg  <= out_addr_next;
        out_rdata_reg <= out_rdata_next;
        out_ior_reg   <= out_ior_next;
        out_iow_reg   <= out_iow_next;
        out_iod_reg   <= out_iod_next;
        out_drop_reg  <= out_drop_next;
        out_last_reg  <= out_last_next;
    end

    bmd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bmd_ram #(
        .WIDTH (8),
        .DEPTH (OS_ROM_DEPTH)
    ) u_os_rom (
        .clk   (clk),
        .we    (os_we),
        .addr  (os_addr),
        .wdata (os_wdata),
        .rdata (os_rdata)
    );

    bmd_ram #(
        .WIDTH (8),
        .DEPTH (CART_ROM_DEPTH)
    ) u_cart_rom (
        .clk   (clk),
        .we    (cart_we),
        .addr  (cart_addr),
        .wdata (cart_wdata),
        .rdata (cart_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_iod_reg, out_rdata_reg, out_addr_reg};
    assign m_axis_tuser  = {out_drop_reg, out_iow_reg, out_ior_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== verif/banked_memory_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// banked_memory_decoder_tb
// Self-checking bench for the banked memory decoder. Access beats go in on
// the slave stream; every byte result coming out of the master stream is
// checked against a shadow copy of RAM, both ROMs and the bank-control byte.
// The run walks through several register settings (flat RAM and banked map,
// bank-control byte at the bottom, top and middle of memory), with bursty
// input traffic and an output side that stalls on a changing pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module banked_memory_decoder_tb;
    import bmd_pkg::*;

    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ACCESSES = 275;   // non-ignored beats per setting
    localparam int SETTLE_CYCLES = 16;     // covers a word read plus shadow reload
    localparam int HOLDOFF_CYCLES = 400;

    // one input beat as the CPU side sees it
    typedef struct {
        mode_t       mode;
        logic [15:0] address;
        logic [15:0] write_data;
        logic        word_access;
    } bus_access_t;

    // one byte result
    typedef struct packed {
        logic [15:0] byte_address;
        logic [7:0]  read_data;
        logic        io_read;
        logic        io_write;
        logic [7:0]  io_data;
        logic        write_dropped;
        logic        last;
    } byte_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;        // address[15:0], write_data[31:16]
    logic [3:0]  s_tuser = '0;        // mode[2:0], word_access[3]

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // byte_address[15:0], read_data[23:16], io_data[31:24]
    logic [2:0]  m_tuser;             // io_read[0], io_write[1], write_dropped[2]
    logic        m_tlast;

    // shadow of the block's memories and registers
    logic [7:0]  ram_shadow  [0:65535];
    logic [7:0]  os_shadow   [0:16383];
    logic [7:0]  cart_shadow [0:8191];
    logic [7:0]  bank_ctrl_shadow;
    logic        io_conn_shadow;
    logic [15:0] bank_addr_shadow;

    bus_access_t  access_q[$];        // beats waiting to be offered
    bus_access_t  offered_access;     // beat currently on the slave bus
    byte_result_t byte_results_due[$];

    int mismatch_count = 0;

    // sender burst/gap state
    int burst_left;
    int gap_left;

    // receiver stall state
    bit holdoff_request = 1'b0;
    int holdoff_left;
    int ready_style;
    int style_left;
    int pattern_step;

    banked_memory_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Byte read through the current map. Direct reads and flat mode bypass
    // all decoding; the I/O window wins over OS ROM, OS ROM over the rest.
    function automatic byte_result_t decode_read(input logic [15:0] addr,
                                                 input logic direct,
                                                 input logic final_byte);
        byte_result_t res;
        logic [15:0]  offset;
        res = '0;
        res.byte_address = addr;
        res.last = final_byte;
        if (direct || !io_conn_shadow)
            res.read_data = ram_shadow[addr];
        else if (addr >= IO_BASE && addr < IO_END)
            res.io_read = 1'b1;
        else if (addr >= OS_BASE && bank_ctrl_shadow[BC_OS_BIT])
        begin
            offset = addr - OS_BASE;
            res.read_data = os_shadow[offset[13:0]];
        end
        else if (addr >= CART_BASE && addr < OS_BASE && !bank_ctrl_shadow[BC_CART_BIT])
        begin
            offset = addr - CART_BASE;
            res.read_data = cart_shadow[offset[12:0]];
        end
        else if (addr >= SELFTEST_BASE && addr < SELFTEST_END
                 && !bank_ctrl_shadow[BC_SELFTEST_BIT] && bank_ctrl_shadow[BC_OS_BIT])
        begin
            // self-test window shows OS ROM from 1000 up
            offset = addr - SELFTEST_BASE + SELFTEST_OFFSET;
            res.read_data = os_shadow[offset[13:0]];
        end
        else
            res.read_data = ram_shadow[addr];
        return res;
    endfunction

    // Byte write through the current map; updates the RAM shadow and the
    // bank-control byte when the store actually lands on its address.
    function automatic byte_result_t decode_write(input logic [15:0] addr,
                                                  input logic [7:0] value,
                                                  input logic direct,
                                                  input logic final_byte);
        byte_result_t res;
        logic         stored;
        res = '0;
        res.byte_address = addr;
        res.last = final_byte;
        stored = 1'b1;
        if (!direct && io_conn_shadow)
        begin
            if (addr >= IO_BASE && addr < IO_END)
            begin
                res.io_write = 1'b1;
                res.io_data = value;
                return res;
            end
            if (addr >= OS_BASE)
                stored = !bank_ctrl_shadow[BC_OS_BIT];
            else if (addr >= CART_BASE)
                stored = bank_ctrl_shadow[BC_CART_BIT];
            else if (addr >= SELFTEST_BASE && addr < SELFTEST_END)
                stored = !bank_ctrl_shadow[BC_OS_BIT] || bank_ctrl_shadow[BC_SELFTEST_BIT];
        end
        if (stored)
        begin
            ram_shadow[addr] = value;
            if (addr == bank_addr_shadow)
                bank_ctrl_shadow = value;
        end
        res.write_dropped = !stored;
        return res;
    endfunction

    // Works out the byte results of one accepted beat. The low byte is
    // handled first, so a word write over the bank byte remaps the high byte.
    task automatic decode_access(input bus_access_t acc);
        logic [15:0] next_addr;
        logic        direct;
        next_addr = acc.address + 16'd1;
        direct = (acc.mode == MODE_DIRECT_READ || acc.mode == MODE_DIRECT_WRITE);
        case (acc.mode)
            MODE_READ, MODE_DIRECT_READ:
            begin
                byte_results_due.push_back(decode_read(acc.address, direct, !acc.word_access));
                if (acc.word_access)
                    byte_results_due.push_back(decode_read(next_addr, direct, 1'b1));
            end
            MODE_WRITE, MODE_DIRECT_WRITE:
            begin
                byte_results_due.push_back(decode_write(acc.address, acc.write_data[7:0],
                                                        direct, !acc.word_access));
                if (acc.word_access)
                    byte_results_due.push_back(decode_write(next_addr, acc.write_data[15:8],
                                                            direct, 1'b1));
            end
            MODE_LOAD_OS:
            begin
                os_shadow[acc.address[13:0]] = acc.write_data[7:0];
                if (acc.word_access)
                    os_shadow[next_addr[13:0]] = acc.write_data[15:8];
            end
            MODE_LOAD_CART:
            begin
                cart_shadow[acc.address[12:0]] = acc.write_data[7:0];
                if (acc.word_access)
                    cart_shadow[next_addr[12:0]] = acc.write_data[15:8];
            end
            default: ;  // reserved modes do nothing
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Slave-side driver: bursts of beats with random gaps in between
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            burst_left = 8;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_access(offered_access);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (access_q.size() != 0)
                begin
                    offered_access = access_q.pop_front();
                    s_tdata <= {offered_access.write_data, offered_access.address};
                    s_tuser <= {offered_access.word_access, offered_access.mode};
                    s_tvalid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        // now and then a long run with no idling at all
                        burst_left = ($urandom_range(0, 15) == 0) ? 300 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Master-side ready: switches between stall styles every so often, and
    // honors a long hold-off when the stimulus asks for one
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            holdoff_left = 0;
            ready_style = 0;
            style_left = 0;
            pattern_step = 0;
        end
        else
        begin
            if (holdoff_request)
            begin
                holdoff_request = 1'b0;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (style_left == 0)
            begin
                ready_style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 200);
            end
            else
                style_left--;
            pattern_step++;

            if (holdoff_left > 0)
            begin
                holdoff_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (ready_style)
                    0:       m_tready <= 1'b1;                          // never stalls
                    1:       m_tready <= 1'($urandom_range(0, 1));      // coin toss
                    2:       m_tready <= ($urandom_range(0, 9) != 0);   // rare stalls
                    default: m_tready <= (pattern_step % 3 != 2);       // fixed rhythm
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string field, input logic [15:0] due,
                               input logic [15:0] seen);
        if (due !== seen)
        begin
            $error("%s mismatch: expected %h, got %h", field, due, seen);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        byte_result_t due;
        byte_result_t seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.byte_address = m_tdata[15:0];
            seen.read_data = m_tdata[23:16];
            seen.io_data = m_tdata[31:24];
            seen.io_read = m_tuser[0];
            seen.io_write = m_tuser[1];
            seen.write_dropped = m_tuser[2];
            seen.last = m_tlast;
            if (byte_results_due.size() == 0)
            begin
                $error("result beat at address %h with nothing expected", seen.byte_address);
                mismatch_count++;
            end
            else
            begin
                due = byte_results_due.pop_front();
                check_field("byte_address", due.byte_address, seen.byte_address);
                check_field("read_data", 16'(due.read_data), 16'(seen.read_data));
                check_field("io_read", 16'(due.io_read), 16'(seen.io_read));
                check_field("io_write", 16'(due.io_write), 16'(seen.io_write));
                check_field("io_data", 16'(due.io_data), 16'(seen.io_data));
                check_field("write_dropped", 16'(due.write_dropped),
                            16'(seen.write_dropped));
                check_field("last", 16'(due.last), 16'(seen.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Register write; the shadow follows at once since the block is idle.
    task automatic write_register(input cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_IO_CONNECTED)
            io_conn_shadow = value[0];
        else
        begin
            bank_addr_shadow = value;
            bank_ctrl_shadow = ram_shadow[value];
        end
        @(negedge clk);
    endtask

    // Waits until every beat is taken and every result has come back, then
    // lets the block finish any load still in flight.
    task automatic wait_drained();
        while (access_q.size() != 0 || s_tvalid || byte_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_access(input mode_t mode, input logic [15:0] addr,
                                input logic [15:0] data, input logic word);
        bus_access_t acc;
        acc.mode = mode;
        acc.address = addr;
        acc.write_data = data;
        acc.word_access = word;
        access_q.push_back(acc);
    endtask

    // Addresses cluster around region edges and the bank byte so that
    // writes, loads and reads keep landing on the same bytes. A raw address
    // also serves as a ROM load offset: the block masks it to the ROM size,
    // which lines up with the window the address falls in.
    function automatic logic [15:0] pick_address();
        logic [15:0] base;
        case ($urandom_range(0, 15))
            0:       base = 16'h0000;
            1:       base = SELFTEST_BASE - 16'd4;
            2:       base = SELFTEST_END - 16'd4;
            3:       base = CART_BASE - 16'd4;
            4:       base = CART_BASE;
            5:       base = OS_BASE - 16'd4;
            6:       base = OS_BASE;
            7:       base = IO_BASE - 16'd4;
            8:       base = IO_BASE;
            9:       base = IO_END - 16'd4;
            10:      base = IO_END;
            11:      base = 16'hFFFC;
            12, 13:  base = bank_addr_shadow - 16'd2;
            14:      base = 16'h5400;
            default: return 16'($urandom_range(0, 65535));
        endcase
        return base + 16'($urandom_range(0, 7));
    endfunction

    function automatic bus_access_t random_access();
        bus_access_t acc;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            acc.mode = MODE_READ;
        else if (pick < 56)
            acc.mode = MODE_WRITE;
        else if (pick < 66)
            acc.mode = MODE_DIRECT_READ;
        else if (pick < 78)
            acc.mode = MODE_DIRECT_WRITE;
        else if (pick < 87)
            acc.mode = MODE_LOAD_OS;
        else if (pick < 96)
            acc.mode = MODE_LOAD_CART;
        else
            acc.mode = pick[0] ? MODE_RSVD7 : MODE_RSVD6;
        acc.address = pick_address();
        // keep the bank byte busy so the map keeps changing
        if ((acc.mode == MODE_WRITE || acc.mode == MODE_DIRECT_WRITE)
            && $urandom_range(0, 5) == 0)
            acc.address = bank_addr_shadow - 16'($urandom_range(0, 1));
        acc.write_data = 16'($urandom_range(0, 65535));
        acc.word_access = 1'($urandom_range(0, 1));
        return acc;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        bus_access_t acc;
        int          counted;
        bit          paused;

        for (int i = 0; i < 65536; i++)
            ram_shadow[i] = 8'h00;
        for (int i = 0; i < 16384; i++)
            os_shadow[i] = 8'h00;
        for (int i = 0; i < 8192; i++)
            cart_shadow[i] = 8'h00;
        bank_ctrl_shadow = 8'h00;
        io_conn_shadow = 1'b0;
        bank_addr_shadow = BANK_ADDR_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // memory clear sweep holds tready low for a while
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    write_register(CFG_IO_CONNECTED, 16'd1);
                    write_register(CFG_BANK_ADDR, BANK_ADDR_RESET);
                end
                1:
                begin
                    write_register(CFG_IO_CONNECTED, 16'd0);
                    write_register(CFG_BANK_ADDR, 16'h0000);
                end
                2:
                begin
                    write_register(CFG_IO_CONNECTED, 16'd1);
                    write_register(CFG_BANK_ADDR, 16'hFFFF);
                end
                3:
                begin
                    write_register(CFG_IO_CONNECTED, 16'd1);
                    write_register(CFG_BANK_ADDR, 16'($urandom_range(0, 65535)));
                end
                4:
                begin
                    write_register(CFG_IO_CONNECTED, 16'd1);
                    write_register(CFG_BANK_ADDR, CART_BASE + 16'd5);
                end
                default:
                begin
                    write_register(CFG_BANK_ADDR, OS_BASE + 16'd1);
                    write_register(CFG_IO_CONNECTED, 16'd0);
                    write_register(CFG_IO_CONNECTED, 16'd1);
                end
            endcase

            if (ph == 0)
            begin
                // ROM images: word loads wrapping at the top of each ROM,
                // and a byte in the self-test area
                queue_access(MODE_LOAD_OS, 16'h0000, 16'hA55A, 1'b1);
                queue_access(MODE_LOAD_OS, 16'h3FFF, 16'h1234, 1'b1);
                queue_access(MODE_LOAD_OS, 16'h1000, 16'h0077, 1'b0);
                queue_access(MODE_LOAD_CART, 16'hFFFF, 16'hBEEF, 1'b1);
                // reserved modes: no result
                queue_access(MODE_RSVD6, 16'hFFFF, 16'hFFFF, 1'b1);
                queue_access(MODE_RSVD7, 16'h0000, 16'h0000, 1'b0);
                // bank byte sits in the I/O window: only a direct write sets it.
                // OS, cartridge and self-test all mapped
                queue_access(MODE_DIRECT_WRITE, BANK_ADDR_RESET, 16'h0001, 1'b0);
                queue_access(MODE_READ, 16'hBFFF, 16'h0000, 1'b1);   // cart -> OS
                queue_access(MODE_READ, 16'hFFFF, 16'h0000, 1'b1);   // OS -> wrap to RAM
                queue_access(MODE_READ, SELFTEST_BASE, 16'h0000, 1'b0);
                queue_access(MODE_WRITE, OS_BASE, 16'hFFFF, 1'b0);   // dropped
                queue_access(MODE_WRITE, CART_BASE, 16'hFFFF, 1'b0); // dropped
                queue_access(MODE_WRITE, 16'h57FF, 16'hFFFF, 1'b0);  // dropped
                queue_access(MODE_WRITE, 16'hD7FF, 16'hCDAB, 1'b1);  // I/O, then OS drop
                queue_access(MODE_READ, IO_BASE, 16'h0000, 1'b1);
                queue_access(MODE_WRITE, 16'hFFFF, 16'hFFFF, 1'b1);  // drop, then wrap store
                queue_access(MODE_DIRECT_READ, 16'hFFFF, 16'h0000, 1'b1);
                // everything unmapped, self-test bit set
                queue_access(MODE_DIRECT_WRITE, BANK_ADDR_RESET, 16'h0082, 1'b0);
                queue_access(MODE_WRITE, OS_BASE, 16'h3C3C, 1'b1);
                queue_access(MODE_READ, OS_BASE, 16'h0000, 1'b1);
                queue_access(MODE_WRITE, CART_BASE, 16'h0011, 1'b0);
                queue_access(MODE_READ, CART_BASE, 16'h0000, 1'b0);
                queue_access(MODE_DIRECT_READ, BANK_ADDR_RESET, 16'h0000, 1'b0);
                queue_access(MODE_WRITE, SELFTEST_BASE, 16'h8181, 1'b1);
                queue_access(MODE_READ, SELFTEST_BASE, 16'h0000, 1'b1);
            end

            // output side goes quiet for a long stretch while beats keep coming
            if (ph == 1)
                holdoff_request = 1'b1;

            counted = 0;
            paused = 1'b0;
            while (counted < PHASE_ACCESSES)
            begin
                acc = random_access();
                access_q.push_back(acc);
                if (acc.mode != MODE_RSVD6 && acc.mode != MODE_RSVD7)
                    counted++;
                // sender stops halfway until the pipeline has emptied
                if (ph == 2 && !paused && counted == PHASE_ACCESSES / 2)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hard stop: clear sweep plus every beat at its slowest, several times over
    initial
    begin : watchdog
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bmd_pkg.sv
rtl/bmd_ram.sv
rtl/banked_memory_decoder.sv
verif/banked_memory_decoder_tb.sv
